// File: rtl/pcpp_pkg.sv
// Shared types, constants and codes for the path command to pen point block.
// Used by the front end, the command queue, the point generator and the top level.
package pcpp_pkg;

   localparam int CURVE_STEPS = 32;
   localparam int STEP_LOG2   = $clog2(CURVE_STEPS);
   localparam int IDX_W       = $clog2(CURVE_STEPS + 1);
   localparam int COORD_W     = 24;
   localparam int ACC_W       = 48;
   localparam int PROD_W      = 49;
   localparam int PLOT_W      = 10;
   localparam int RESULT_CAP  = 32;
   localparam int MAX_INNER   = RESULT_CAP - 1;
   localparam int CNT_W       = $clog2(RESULT_CAP);

   localparam logic [3:0] OP_MOVE    = 4'd0;
   localparam logic [3:0] OP_LINE    = 4'd1;
   localparam logic [3:0] OP_QUAD    = 4'd2;
   localparam logic [3:0] OP_SQUAD   = 4'd3;
   localparam logic [3:0] OP_CUBIC   = 4'd4;
   localparam logic [3:0] OP_SCUBIC  = 4'd5;
   localparam logic [3:0] OP_CLOSE   = 4'd6;
   localparam logic [3:0] OP_RECT    = 4'd7;
   localparam logic [3:0] OP_LELEM   = 4'd8;

   localparam logic CSR_SCALE    = 1'b0;
   localparam logic CSR_MIN_STEP = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [2:0] {
      CLS_MOVE,
      CLS_LINE,
      CLS_CLOSE,
      CLS_RECT,
      CLS_LELEM,
      CLS_QUAD,
      CLS_CUBIC
   } cls_type;

   typedef struct packed {
      cls_type   cls;
      coord_type p0x;
      coord_type p0y;
      coord_type c1x;
      coord_type c1y;
      coord_type c2x;
      coord_type c2y;
      coord_type ex;
      coord_type ey;
   } cmd_type;

   typedef struct packed {
      logic [23:0] scale;
      logic [15:0] min_step;
   } cfg_type;

   typedef struct packed {
      logic       full;
      logic       empty;
      logic [1:0] count;
   } qstat_type;

endpackage

// File: rtl/pcpp_front.sv
// Front end: accepts drawing commands, resolves absolute coordinates and keeps
// the pen, subpath and control point state. Depends on pcpp_pkg.
module pcpp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [4:0]       req_tuser,
   input  logic [143:0]     req_tdata,
   input  logic             q_full,
   output logic             q_push,
   output pcpp_pkg::cmd_type q_cmd
);
   import pcpp_pkg::*;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_QUAD  = 2'd1;
   localparam logic [1:0] KIND_CUBIC = 2'd2;

   coord_type pen_x_ff, pen_y_ff, sub_x_ff, sub_y_ff, lc_x_ff, lc_y_ff;
   coord_type pen_x_in, pen_y_in, sub_x_in, sub_y_in, lc_x_in, lc_y_in;
   logic [1:0] kind_ff, kind_in;

   logic [3:0] opcode;
   logic       relative;
   coord_type  f_ax, f_ay, f_bx, f_by, f_ex, f_ey;
   coord_type  ax, ay, bx, by, ex, ey, rx, ry, x2, y2;
   logic       valid_op;

   function automatic coord_type sat(input logic signed [25:0] v);
      coord_type r;
      if (v > 26'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -26'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   function automatic coord_type rel_add(input coord_type f, input coord_type base,
                                          input logic rel);
      coord_type r;
      if (rel) begin
         r = sat(26'(f) + 26'(base));
      end else begin
         r = f;
      end
      return r;
   endfunction

   assign opcode   = req_tuser[3:0];
   assign relative = req_tuser[4];
   assign f_ax = req_tdata[23:0];
   assign f_ay = req_tdata[47:24];
   assign f_bx = req_tdata[71:48];
   assign f_by = req_tdata[95:72];
   assign f_ex = req_tdata[119:96];
   assign f_ey = req_tdata[143:120];

   always_comb begin
      ax = rel_add(f_ax, pen_x_ff, relative);
      ay = rel_add(f_ay, pen_y_ff, relative);
      bx = rel_add(f_bx, pen_x_ff, relative);
      by = rel_add(f_by, pen_y_ff, relative);
      ex = rel_add(f_ex, pen_x_ff, relative);
      ey = rel_add(f_ey, pen_y_ff, relative);
      rx = sat({pen_x_ff[23], pen_x_ff, 1'b0} - 26'(lc_x_ff));
      ry = sat({pen_y_ff[23], pen_y_ff, 1'b0} - 26'(lc_y_ff));
      x2 = sat(26'(ax) + 26'(f_bx));
      y2 = sat(26'(ay) + 26'(f_by));
   end

   always_comb begin
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      sub_x_in = sub_x_ff;
      sub_y_in = sub_y_ff;
      lc_x_in  = lc_x_ff;
      lc_y_in  = lc_y_ff;
      kind_in  = KIND_NONE;
      valid_op = 1'b1;
      q_cmd     = '0;
      q_cmd.cls = CLS_MOVE;
      q_cmd.p0x = pen_x_ff;
      q_cmd.p0y = pen_y_ff;
      q_cmd.ex  = ex;
      q_cmd.ey  = ey;
      case (opcode)
         OP_MOVE: begin
            pen_x_in = ex;
            pen_y_in = ey;
            sub_x_in = ex;
            sub_y_in = ey;
         end
         OP_LINE: begin
            q_cmd.cls = CLS_LINE;
            pen_x_in = ex;
            pen_y_in = ey;
         end
         OP_QUAD, OP_SQUAD: begin
            q_cmd.cls = CLS_QUAD;
            if (opcode == OP_QUAD) begin
               q_cmd.c1x = ax;
               q_cmd.c1y = ay;
            end else if (kind_ff == KIND_QUAD) begin
               q_cmd.c1x = rx;
               q_cmd.c1y = ry;
            end else begin
               q_cmd.c1x = pen_x_ff;
               q_cmd.c1y = pen_y_ff;
            end
            lc_x_in  = q_cmd.c1x;
            lc_y_in  = q_cmd.c1y;
            kind_in  = KIND_QUAD;
            pen_x_in = ex;
            pen_y_in = ey;
         end
         OP_CUBIC, OP_SCUBIC: begin
            q_cmd.cls = CLS_CUBIC;
            if (opcode == OP_CUBIC) begin
               q_cmd.c1x = ax;
               q_cmd.c1y = ay;
            end else if (kind_ff == KIND_CUBIC) begin
               q_cmd.c1x = rx;
               q_cmd.c1y = ry;
            end else begin
               q_cmd.c1x = pen_x_ff;
               q_cmd.c1y = pen_y_ff;
            end
            q_cmd.c2x = bx;
            q_cmd.c2y = by;
            lc_x_in  = bx;
            lc_y_in  = by;
            kind_in  = KIND_CUBIC;
            pen_x_in = ex;
            pen_y_in = ey;
         end
         OP_CLOSE: begin
            q_cmd.cls = CLS_CLOSE;
            q_cmd.ex  = sub_x_ff;
            q_cmd.ey  = sub_y_ff;
            pen_x_in  = sub_x_ff;
            pen_y_in  = sub_y_ff;
         end
         OP_RECT: begin
            q_cmd.cls = CLS_RECT;
            q_cmd.c1x = ax;
            q_cmd.c1y = ay;
            q_cmd.c2x = x2;
            q_cmd.c2y = y2;
            pen_x_in  = ax;
            pen_y_in  = ay;
            sub_x_in  = ax;
            sub_y_in  = ay;
         end
         OP_LELEM: begin
            q_cmd.cls = CLS_LELEM;
            q_cmd.c1x = ax;
            q_cmd.c1y = ay;
            sub_x_in  = ax;
            sub_y_in  = ay;
            pen_x_in  = ex;
            pen_y_in  = ey;
         end
         default: begin
            valid_op = 1'b0;
            kind_in  = kind_ff;
         end
      endcase
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready && valid_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         sub_x_ff <= '0;
         sub_y_ff <= '0;
         lc_x_ff  <= '0;
         lc_y_ff  <= '0;
         kind_ff  <= KIND_NONE;
      end else if (q_push) begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         sub_x_ff <= sub_x_in;
         sub_y_ff <= sub_y_in;
         lc_x_ff  <= lc_x_in;
         lc_y_ff  <= lc_y_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// File: rtl/pcpp_queue.sv
// Two-entry command queue between the front end and the point generator.
// Depends on pcpp_pkg for the command record.
module pcpp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pcpp_pkg::cmd_type   push_cmd,
   input  logic                pop,
   output pcpp_pkg::cmd_type   pop_cmd,
   output pcpp_pkg::qstat_type stat
);
   import pcpp_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign stat.count = count_ff;
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/pcpp_back.sv
// Point generator: walks each queued command, steps curves by forward
// differences, scales, filters and rounds the points. Depends on pcpp_pkg.
module pcpp_back (
   input  logic                clock,
   input  logic                reset,
   input  pcpp_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  pcpp_pkg::cmd_type   q_cmd,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // plot_x, plot_y, zero fill
   output logic                rsp_tuser,   // pen_down
   output logic                rsp_tlast
);
   import pcpp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_COEF = 3'b010,
      ST_RUN  = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      TAG_PLAIN,
      TAG_FILTER,
      TAG_INIT
   } tag_type;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      acc_type f0;
      acc_type a;
      acc_type b;
      acc_type c;
   } coef_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff;
   logic [IDX_W-1:0] idx_ff;
   acc_type fx_ff, fy_ff, d1x_ff, d1y_ff, d2x_ff, d2y_ff, d3x_ff, d3y_ff;
   coef_type cx, cy;

   logic      adv;
   logic      curve;
   logic [IDX_W-1:0] last_idx;
   tag_type   c_tag;
   logic      c_down, c_last;
   coord_type c_x, c_y;

   logic      s1_valid_ff;
   tag_type   s1_tag_ff;
   logic      s1_down_ff, s1_last_ff;
   coord_type s1_x_ff, s1_y_ff;

   logic      s2_valid_ff;
   tag_type   s2_tag_ff;
   logic      s2_down_ff, s2_last_ff;
   logic signed [PROD_W-1:0] s2_px_ff, s2_py_ff;

   logic signed [PROD_W-1:0] lx_ff, ly_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic signed [PROD_W:0] dx, dy, adx, ady, thr;
   logic      far, emit;

   logic rsp_valid_ff;
   logic [PLOT_W-1:0] plot_x_ff, plot_y_ff;
   logic rsp_down_ff, rsp_last_ff;

   function automatic coef_type coef(input coord_type p0, input coord_type c1,
                                     input coord_type c2, input coord_type e,
                                     input logic cubic);
      coef_type r;
      acc_type  p, q1, q2, en, t, u, v;
      p  = ACC_W'(p0);
      q1 = ACC_W'(c1);
      q2 = ACC_W'(c2);
      en = ACC_W'(e);
      t  = q1 - p;
      if (cubic) begin
         u   = p - (q1 <<< 1) + q2;
         v   = q1 - q2;
         r.f0 = p <<< (3 * STEP_LOG2);
         r.a  = (t + (t <<< 1)) <<< (2 * STEP_LOG2);
         r.b  = (u + (u <<< 1)) <<< STEP_LOG2;
         r.c  = en - p + v + (v <<< 1);
      end else begin
         u   = p - (q1 <<< 1) + en;
         v   = '0;
         r.f0 = p <<< (2 * STEP_LOG2);
         r.a  = t <<< (STEP_LOG2 + 1);
         r.b  = u;
         r.c  = v;
      end
      return r;
   endfunction

   function automatic coord_type round_sat(input acc_type f, input logic cubic);
      acc_type   s;
      coord_type r;
      if (cubic) begin
         s = (f + (acc_type'(1) <<< (3 * STEP_LOG2 - 1))) >>> (3 * STEP_LOG2);
      end else begin
         s = (f + (acc_type'(1) <<< (2 * STEP_LOG2 - 1))) >>> (2 * STEP_LOG2);
      end
      if (s > acc_type'(8388607)) begin
         r = 24'sh7FFFFF;
      end else if (s < -acc_type'(8388608)) begin
         r = 24'sh800000;
      end else begin
         r = s[23:0];
      end
      return r;
   endfunction

   function automatic logic [PLOT_W-1:0] to_plot(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] s;
      logic [PLOT_W-1:0] r;
      s = ((PROD_W + 1)'(p) + (PROD_W + 1)'(64'sd8388608)) >>> 24;
      if (p < 0) begin
         r = '0;
      end else if (s > (PROD_W + 1)'(64'sd1023)) begin
         r = '1;
      end else begin
         r = s[PLOT_W-1:0];
      end
      return r;
   endfunction

   assign adv   = !rsp_valid_ff || rsp_tready;
   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign curve = (cmd_ff.cls == CLS_QUAD) || (cmd_ff.cls == CLS_CUBIC);

   always_comb begin
      cx = coef(q_cmd.p0x, q_cmd.c1x, q_cmd.c2x, q_cmd.ex, q_cmd.cls == CLS_CUBIC);
      cy = coef(q_cmd.p0y, q_cmd.c1y, q_cmd.c2y, q_cmd.ey, q_cmd.cls == CLS_CUBIC);
   end

   always_comb begin
      c_tag  = TAG_PLAIN;
      c_down = 1'b1;
      c_last = 1'b0;
      c_x    = cmd_ff.ex;
      c_y    = cmd_ff.ey;
      last_idx = '0;
      case (cmd_ff.cls)
         CLS_MOVE: begin
            c_down = 1'b0;
            c_last = 1'b1;
         end
         CLS_LINE, CLS_CLOSE: begin
            c_last = 1'b1;
         end
         CLS_LELEM: begin
            last_idx = IDX_W'(1);
            if (idx_ff == '0) begin
               c_down = 1'b0;
               c_x    = cmd_ff.c1x;
               c_y    = cmd_ff.c1y;
            end else begin
               c_last = 1'b1;
            end
         end
         CLS_RECT: begin
            last_idx = IDX_W'(4);
            case (idx_ff)
               IDX_W'(0): begin
                  c_down = 1'b0;
                  c_x    = cmd_ff.c1x;
                  c_y    = cmd_ff.c1y;
               end
               IDX_W'(1): begin
                  c_x = cmd_ff.c2x;
                  c_y = cmd_ff.c1y;
               end
               IDX_W'(2): begin
                  c_x = cmd_ff.c2x;
                  c_y = cmd_ff.c2y;
               end
               IDX_W'(3): begin
                  c_x = cmd_ff.c1x;
                  c_y = cmd_ff.c2y;
               end
               default: begin
                  c_x    = cmd_ff.c1x;
                  c_y    = cmd_ff.c1y;
                  c_last = 1'b1;
               end
            endcase
         end
         CLS_QUAD, CLS_CUBIC: begin
            last_idx = IDX_W'(CURVE_STEPS);
            if (idx_ff == '0) begin
               c_tag = TAG_INIT;
               c_x   = cmd_ff.p0x;
               c_y   = cmd_ff.p0y;
            end else if (idx_ff == IDX_W'(CURVE_STEPS)) begin
               c_last = 1'b1;
            end else begin
               c_tag = TAG_FILTER;
               c_x   = round_sat(fx_ff, cmd_ff.cls == CLS_CUBIC);
               c_y   = round_sat(fy_ff, cmd_ff.cls == CLS_CUBIC);
            end
         end
         default: begin
            c_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if ((q_cmd.cls == CLS_QUAD) || (q_cmd.cls == CLS_CUBIC)) begin
                  state_in = ST_COEF;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_COEF: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (adv && (idx_ff == last_idx)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_ff <= q_cmd;
               idx_ff <= '0;
               fx_ff  <= cx.f0;
               fy_ff  <= cy.f0;
               d1x_ff <= cx.a;
               d1y_ff <= cy.a;
               d2x_ff <= cx.b;
               d2y_ff <= cy.b;
               d3x_ff <= cx.c;
               d3y_ff <= cy.c;
            end
         end
         ST_COEF: begin
            d1x_ff <= d1x_ff + d2x_ff + d3x_ff;
            d1y_ff <= d1y_ff + d2y_ff + d3y_ff;
            d2x_ff <= (d2x_ff <<< 1) + (d3x_ff <<< 2) + (d3x_ff <<< 1);
            d2y_ff <= (d2y_ff <<< 1) + (d3y_ff <<< 2) + (d3y_ff <<< 1);
            d3x_ff <= (d3x_ff <<< 2) + (d3x_ff <<< 1);
            d3y_ff <= (d3y_ff <<< 2) + (d3y_ff <<< 1);
         end
         ST_RUN: begin
            if (adv) begin
               idx_ff <= idx_ff + IDX_W'(1);
               if (curve) begin
                  fx_ff  <= fx_ff + d1x_ff;
                  fy_ff  <= fy_ff + d1y_ff;
                  d1x_ff <= d1x_ff + d2x_ff;
                  d1y_ff <= d1y_ff + d2y_ff;
                  d2x_ff <= d2x_ff + d3x_ff;
                  d2y_ff <= d2y_ff + d3y_ff;
               end
            end
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= (state_ff == ST_RUN);
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff  <= c_tag;
         s1_down_ff <= c_down;
         s1_last_ff <= c_last;
         s1_x_ff    <= c_x;
         s1_y_ff    <= c_y;
         s2_tag_ff  <= s1_tag_ff;
         s2_down_ff <= s1_down_ff;
         s2_last_ff <= s1_last_ff;
         s2_px_ff   <= s1_x_ff * $signed({1'b0, cfg.scale});
         s2_py_ff   <= s1_y_ff * $signed({1'b0, cfg.scale});
      end
   end

   always_comb begin
      dx  = (PROD_W + 1)'(s2_px_ff) - (PROD_W + 1)'(lx_ff);
      dy  = (PROD_W + 1)'(s2_py_ff) - (PROD_W + 1)'(ly_ff);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      thr = $signed({{(PROD_W - 31){1'b0}}, cfg.min_step, 16'b0});
      far = (adx >= thr) || (ady >= thr);
      case (s2_tag_ff)
         TAG_PLAIN:  emit = s2_valid_ff;
         TAG_FILTER: emit = s2_valid_ff && far && (cnt_ff < CNT_W'(MAX_INNER));
         default:    emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         if (s2_tag_ff == TAG_INIT) begin
            lx_ff  <= s2_px_ff;
            ly_ff  <= s2_py_ff;
            cnt_ff <= '0;
         end else if (emit && (s2_tag_ff == TAG_FILTER)) begin
            lx_ff  <= s2_px_ff;
            ly_ff  <= s2_py_ff;
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
      if (adv && emit) begin
         plot_x_ff   <= to_plot(s2_px_ff);
         plot_y_ff   <= to_plot(s2_py_ff);
         rsp_down_ff <= s2_down_ff;
         rsp_last_ff <= s2_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, plot_y_ff, plot_x_ff};
   assign rsp_tuser  = rsp_down_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/path_command_to_pen_points.sv
// Top level: turns drawing commands into plotter pen points.
// In the point generator a curve is loaded, set up in the coefficient state and then
// stepped one sample at a time; a point command is loaded and then steps through its points.
// A command taken from the two-entry queue reaches the output through the command register,
// the stage 1 and stage 2 registers and the output register; a curve also passes the coefficient state.
// The queue lets the front end take up to two commands ahead of the generator.
// Synchronous reset clears the pen state, the queue and the pipeline and loads the
// default scale and step registers.
module path_command_to_pen_points (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y
   input  logic [4:0]   req_tuser,  // opcode, relative
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,  // plot_x, plot_y, zero fill
   output logic         rsp_tuser,  // pen_down
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [23:0]  csr_wdata
);
   import pcpp_pkg::*;

   cfg_type   cfg_ff;
   logic      q_push, q_pop;
   cmd_type   push_cmd, pop_cmd;
   qstat_type q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale    <= 24'd65536;
         cfg_ff.min_step <= 16'd512;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCALE:    cfg_ff.scale    <= csr_wdata;
            CSR_MIN_STEP: cfg_ff.min_step <= csr_wdata[15:0];
            default:      cfg_ff          <= cfg_ff;
         endcase
      end
   end

   pcpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_stat.full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   pcpp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .stat     (q_stat)
   );

   pcpp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (!q_stat.empty),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count != 2'd3)
      else $error("command queue count out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("command taken from an empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push && !q_pop |=> !q_stat.empty)
      else $error("queued command lost");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && q_stat.empty)
      else $error("output word or queue entry present after reset");
`endif

endmodule

// File: test/path_command_to_pen_points_test.sv
// Self-checking regression for the path command to pen point block.
// Drives drawing commands with bursty timing, predicts pen points in a local model
// and compares every result word; depends on pcpp_pkg and path_command_to_pen_points.
module path_command_to_pen_points_test;
   import pcpp_pkg::*;

   typedef struct packed {
      logic [3:0]  opcode;
      logic        relative;
      logic [23:0] ax, ay, bx, by, ex, ey;
   } command_type;

   typedef struct packed {
      logic       pen_down;
      logic [9:0] px, py;
      logic       last;
   } point_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic [4:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [23:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 0;
   logic         csr_index = CSR_SCALE;
   logic [23:0]  csr_wdata = '0;

   path_command_to_pen_points u_top (.*);

   initial forever #5 clock = ~clock;

   command_type pending_cmds[$];
   point_type   expected_points[$];
   int       errors = 0;
   int       cycles = 0;
   int       gap_left = 0, burst_left = 0;
   int       hold_off = 0;
   bit       random_stall = 1;
   int       sent = 0;

   // Local copy of the block's state.
   logic [23:0] m_scale;
   logic [15:0] m_step;
   longint      m_pen_x, m_pen_y, m_sub_x, m_sub_y, m_ctl_x, m_ctl_y;
   int          m_kind;

   function automatic longint sat24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint sext(logic [23:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint fdiv(longint n, longint d);
      longint q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic logic [9:0] plot_of(longint c);
      longint p = c * longint'(m_scale);
      longint r;
      if (p < 0) return 10'd0;
      r = (p + (longint'(1) << 23)) >>> 24;
      return (r > 1023) ? 10'd1023 : r[9:0];
   endfunction

   task automatic push_point(bit down, longint x, longint y, bit last);
      point_type p;
      p.pen_down = down;
      p.px = plot_of(x);
      p.py = plot_of(y);
      p.last = last;
      expected_points.push_back(p);
   endtask

   task automatic sample_curve(bit cubic, longint c1x, longint c1y, longint c2x,
                               longint c2y, longint ex, longint ey);
      longint n = CURVE_STEPS;
      longint d = cubic ? n * n * n : n * n;
      longint lx = m_pen_x * m_scale, ly = m_pen_y * m_scale;
      longint thr = longint'(m_step) << 16;
      longint j, w0, w1, w2, w3, nx, ny, sx, sy, dx, dy;
      int cnt = 0;
      for (longint k = 1; k < n; k++) begin
         j = n - k;
         if (cubic) begin
            w0 = j*j*j; w1 = 3*k*j*j; w2 = 3*k*k*j; w3 = k*k*k;
         end else begin
            w0 = j*j; w1 = 2*k*j; w2 = 0; w3 = k*k;
         end
         nx = w0*m_pen_x + w1*c1x + w2*c2x + w3*ex;
         ny = w0*m_pen_y + w1*c1y + w2*c2y + w3*ey;
         sx = sat24(fdiv(2*nx + d, 2*d));
         sy = sat24(fdiv(2*ny + d, 2*d));
         dx = sx*m_scale - lx; if (dx < 0) dx = -dx;
         dy = sy*m_scale - ly; if (dy < 0) dy = -dy;
         if ((dx >= thr || dy >= thr) && cnt < RESULT_CAP - 1) begin
            push_point(1, sx, sy, 0);
            cnt++;
            lx = sx*m_scale; ly = sy*m_scale;
         end
      end
      push_point(1, ex, ey, 1);
      m_pen_x = ex; m_pen_y = ey;
   endtask

   task automatic predict_points(command_type c);
      longint rx = c.relative ? m_pen_x : 0;
      longint ry = c.relative ? m_pen_y : 0;
      longint ex = sat24(sext(c.ex) + rx), ey = sat24(sext(c.ey) + ry);
      longint ax = sat24(sext(c.ax) + rx), ay = sat24(sext(c.ay) + ry);
      longint bx = sat24(sext(c.bx) + rx), by = sat24(sext(c.by) + ry);
      longint c1x, c1y, x2, y2;
      case (c.opcode)
         OP_MOVE: begin
            push_point(0, ex, ey, 1);
            m_pen_x = ex; m_pen_y = ey; m_sub_x = ex; m_sub_y = ey; m_kind = 0;
         end
         OP_LINE: begin
            push_point(1, ex, ey, 1);
            m_pen_x = ex; m_pen_y = ey; m_kind = 0;
         end
         OP_QUAD, OP_SQUAD: begin
            if (c.opcode == OP_QUAD) begin
               c1x = ax; c1y = ay;
            end else if (m_kind == 1) begin
               c1x = sat24(2*m_pen_x - m_ctl_x); c1y = sat24(2*m_pen_y - m_ctl_y);
            end else begin
               c1x = m_pen_x; c1y = m_pen_y;
            end
            m_ctl_x = c1x; m_ctl_y = c1y; m_kind = 1;
            sample_curve(0, c1x, c1y, 0, 0, ex, ey);
         end
         OP_CUBIC, OP_SCUBIC: begin
            if (c.opcode == OP_CUBIC) begin
               c1x = ax; c1y = ay;
            end else if (m_kind == 2) begin
               c1x = sat24(2*m_pen_x - m_ctl_x); c1y = sat24(2*m_pen_y - m_ctl_y);
            end else begin
               c1x = m_pen_x; c1y = m_pen_y;
            end
            m_ctl_x = bx; m_ctl_y = by; m_kind = 2;
            sample_curve(1, c1x, c1y, bx, by, ex, ey);
         end
         OP_CLOSE: begin
            push_point(1, m_sub_x, m_sub_y, 1);
            m_pen_x = m_sub_x; m_pen_y = m_sub_y; m_kind = 0;
         end
         OP_RECT: begin
            x2 = sat24(ax + sext(c.bx)); y2 = sat24(ay + sext(c.by));
            push_point(0, ax, ay, 0);
            push_point(1, x2, ay, 0);
            push_point(1, x2, y2, 0);
            push_point(1, ax, y2, 0);
            push_point(1, ax, ay, 1);
            m_pen_x = ax; m_pen_y = ay; m_sub_x = ax; m_sub_y = ay; m_kind = 0;
         end
         OP_LELEM: begin
            push_point(0, ax, ay, 0);
            push_point(1, ex, ey, 1);
            m_sub_x = ax; m_sub_y = ay; m_pen_x = ex; m_pen_y = ey; m_kind = 0;
         end
         default: ;
      endcase
   endtask

   // Driver: bursts with random gaps; prediction is made when a word is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_points(pending_cmds.pop_front());
            sent++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0 || pending_cmds.size() == 0) begin
               req_tvalid <= 0;
               if (gap_left > 0) gap_left--;
            end else begin
               req_tvalid <= 1;
               req_tdata <= {pending_cmds[0].ey, pending_cmds[0].ex, pending_cmds[0].by,
                             pending_cmds[0].bx, pending_cmds[0].ay, pending_cmds[0].ax};
               req_tuser <= {pending_cmds[0].relative, pending_cmds[0].opcode};
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 8);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
      end
   end

   // Monitor and receiver stall pattern.
   always @(posedge clock) begin
      point_type got, want;
      cycles++;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[9:0], rsp_tdata[19:10], rsp_tlast};
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected word %h", $time, got);
               errors++;
            end else begin
               want = expected_points.pop_front();
               if (got !== want)
                  $display("%0t: mismatch expected pen %b x %0d y %0d last %b, actual pen %b x %0d y %0d last %b",
                           $time, want.pen_down, want.px, want.py, want.last,
                           got.pen_down, got.px, got.py, got.last);
               if (got !== want) errors++;
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 0;
         end else if (random_stall)
            rsp_tready <= ((cycles % 23) < 15) ? ($urandom_range(0, 3) != 0) : ((cycles / 23) % 3 == 0);
         else
            rsp_tready <= 1;
      end
      if (cycles > 2000000) begin
         $display("path_command_to_pen_points regression: fail");
         $finish;
      end
   end

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'($urandom());
         default: return 24'($urandom_range(0, 1023 * 256));
      endcase
   endfunction

   task automatic add_cmd(logic [3:0] op, bit rel, logic [23:0] ax, logic [23:0] ay,
                          logic [23:0] bx, logic [23:0] by, logic [23:0] ex,
                          logic [23:0] ey);
      pending_cmds.push_back('{op, rel, ax, ay, bx, by, ex, ey});
   endtask

   task automatic add_random(int n);
      logic [3:0] op;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
         add_cmd(op, 1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() != 0 || req_tvalid || expected_points.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [23:0] v);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CSR_SCALE) m_scale = v; else m_step = v[15:0];
   endtask

   initial begin
      m_scale = 24'd65536; m_step = 16'd512;
      m_pen_x = 0; m_pen_y = 0; m_sub_x = 0; m_sub_y = 0;
      m_ctl_x = 0; m_ctl_y = 0; m_kind = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: every opcode, both flags, extreme coordinates, smooth reflections.
      add_cmd(OP_MOVE, 0, 0, 0, 0, 0, 24'd2560, 24'd2560);
      add_cmd(OP_LINE, 1, 0, 0, 0, 0, 24'd25600, 24'd0);
      add_cmd(OP_QUAD, 0, 24'd51200, 24'd51200, 0, 0, 24'd76800, 24'd2560);
      add_cmd(OP_SQUAD, 1, 0, 0, 0, 0, 24'd25600, 24'd25600);
      add_cmd(OP_SQUAD, 0, 0, 0, 0, 0, 24'd1000, 24'd90000);
      add_cmd(OP_CUBIC, 0, 24'd0, 24'd200000, 24'd200000, 24'd0, 24'd100000, 24'd100000);
      add_cmd(OP_SCUBIC, 1, 0, 0, 24'hFF0000, 24'd5000, 24'hFFC000, 24'd3000);
      add_cmd(OP_SCUBIC, 0, 0, 0, 24'd9000, 24'd9000, 24'd0, 24'd0);
      add_cmd(OP_CLOSE, 1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      add_cmd(OP_RECT, 0, 24'd5120, 24'd5120, 24'd51200, 24'hFF0000, 0, 0);
      add_cmd(OP_RECT, 1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 0, 0);
      add_cmd(OP_LELEM, 0, 24'h800000, 24'h7FFFFF, 0, 0, 24'h7FFFFF, 24'h800000);
      add_cmd(OP_LELEM, 1, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 24'h7FFFFF, 24'h7FFFFF);
      add_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_SCUBIC, 0, 0, 0, 24'd100, 24'd100, 24'd20000, 24'd20000);
      add_cmd(OP_QUAD, 1, 24'h800000, 24'h7FFFFF, 0, 0, 24'h7FFFFF, 24'h800000);
      add_cmd(4'd9, 1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
      add_cmd(4'd15, 0, 0, 0, 0, 0, 0, 0);
      wait_idle();
      // Zero step and maximum scale: every inner sample, heavy saturation.
      write_csr(CSR_MIN_STEP, 24'd0);
      write_csr(CSR_SCALE, 24'hFFFFFF);
      add_cmd(OP_MOVE, 0, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_CUBIC, 0, 24'd100, 24'd50, 24'd200, 24'd300, 24'd400, 24'd20);
      add_random(15);
      wait_idle();
      // Long receiver hold-off while the sender keeps offering.
      write_csr(CSR_SCALE, 24'd0);
      write_csr(CSR_MIN_STEP, 24'hFFFF);
      hold_off = 400;
      add_random(15);
      wait_idle();
      write_csr(CSR_SCALE, 24'd65536 * 3);
      write_csr(CSR_MIN_STEP, 24'd256);
      add_random(25);
      wait_idle();
      random_stall = 0;
      write_csr(CSR_SCALE, 24'd40000);
      write_csr(CSR_MIN_STEP, 24'd1);
      add_random(25);
      wait_idle();
      if (errors == 0)
         $display("path_command_to_pen_points regression: pass");
      else
         $display("path_command_to_pen_points regression: fail");
      $finish;
   end
endmodule
